[hdl/spr_pkg.sv]
// Shared types and codes for the sorted peer set union block.
package spr_pkg;

  // Upper bounds that size the command word between front and back
  localparam int unsigned PEER_W_MAX  = 64;
  localparam int unsigned IDX_W_MAX   = 6;
  localparam int unsigned CNT_W_MAX   = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD_CUR = 2'd0,
    OP_LOAD_RDY = 2'd1,
    OP_FINISH   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_BAD_CURRENT = 3'd0,
    ST_BAD_READY   = 3'd1,
    ST_CAPACITY    = 3'd2,
    ST_UNCHANGED   = 3'd3,
    ST_DEFERRED    = 3'd4,
    ST_PUBLISHED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_LOAD_CUR = 2'd0,
    CMD_LOAD_RDY = 2'd1,
    CMD_FINISH   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_MERGE  = 2'd1,
    B_DECIDE = 2'd2,
    B_EMIT   = 2'd3
  } back_state_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [PEER_W_MAX-1:0]   value;
    logic [IDX_W_MAX-1:0]    idx;
    logic [CNT_W_MAX-1:0]    cur_count;
    logic [CNT_W_MAX-1:0]    rdy_count;
    logic                    cur_bad;
    logic                    rdy_bad;
    logic                    fresh;
  } cmd_t;

endpackage

[hdl/spr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module spr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/spr_front.sv]
// Front end: accepts requests, checks set order and size, queues store and finish commands.
module spr_front #(
  parameter int unsigned MAX_PEERS = 16,
  parameter int unsigned PEER_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    op_i,
  input  logic [63:0]   peer_in_i,
  input  logic          fresh_boundary_i,
  input  logic          full_i,
  output logic          push_o,
  output spr_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);

  logic [CNT_W-1:0]     cnt_cur_q, cnt_cur_d, cnt_rdy_q, cnt_rdy_d;
  logic                 bad_cur_q, bad_cur_d, bad_rdy_q, bad_rdy_d;
  logic [PEER_BITS-1:0] last_cur_q, last_cur_d, last_rdy_q, last_rdy_d;
  logic [PEER_BITS-1:0] v;
  logic [CNT_W-1:0]     cnt_sel;
  logic [PEER_BITS-1:0] last_sel;
  logic                 is_rdy, load_bad, accept;

  always_comb begin
    accept   = in_valid_i && !full_i;
    v        = peer_in_i[PEER_BITS-1:0];
    is_rdy   = (op_i == spr_pkg::OP_LOAD_RDY);
    cnt_sel  = is_rdy ? cnt_rdy_q : cnt_cur_q;
    last_sel = is_rdy ? last_rdy_q : last_cur_q;
    load_bad = (v == '0) || (cnt_sel == CNT_W'(MAX_PEERS)) ||
               ((cnt_sel != '0) && !(last_sel < v));

    cnt_cur_d  = cnt_cur_q;
    cnt_rdy_d  = cnt_rdy_q;
    bad_cur_d  = bad_cur_q;
    bad_rdy_d  = bad_rdy_q;
    last_cur_d = last_cur_q;
    last_rdy_d = last_rdy_q;
    push_o     = 1'b0;

    cmd_o           = '0;
    cmd_o.kind      = spr_pkg::CMD_FINISH;
    cmd_o.value     = spr_pkg::PEER_W_MAX'(v);
    cmd_o.idx       = spr_pkg::IDX_W_MAX'(cnt_sel);
    cmd_o.cur_count = spr_pkg::CNT_W_MAX'(cnt_cur_q);
    cmd_o.rdy_count = spr_pkg::CNT_W_MAX'(cnt_rdy_q);
    cmd_o.cur_bad   = bad_cur_q;
    cmd_o.rdy_bad   = bad_rdy_q;
    cmd_o.fresh     = fresh_boundary_i;

    if (accept) begin
      unique case (op_i)
        spr_pkg::OP_LOAD_CUR: begin
          if (load_bad) begin
            bad_cur_d = 1'b1;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = spr_pkg::CMD_LOAD_CUR;
            cnt_cur_d  = cnt_cur_q + 1'b1;
            last_cur_d = v;
          end
        end
        spr_pkg::OP_LOAD_RDY: begin
          if (load_bad) begin
            bad_rdy_d = 1'b1;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = spr_pkg::CMD_LOAD_RDY;
            cnt_rdy_d  = cnt_rdy_q + 1'b1;
            last_rdy_d = v;
          end
        end
        spr_pkg::OP_FINISH: begin
          // Hand the round over to the back end and start a fresh one
          push_o    = 1'b1;
          cnt_cur_d = '0;
          cnt_rdy_d = '0;
          bad_cur_d = 1'b0;
          bad_rdy_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cur_q <= '0;
      cnt_rdy_q <= '0;
      bad_cur_q <= 1'b0;
      bad_rdy_q <= 1'b0;
    end else begin
      cnt_cur_q <= cnt_cur_d;
      cnt_rdy_q <= cnt_rdy_d;
      bad_cur_q <= bad_cur_d;
      bad_rdy_q <= bad_rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_cur_q <= last_cur_d;
    last_rdy_q <= last_rdy_d;
  end

endmodule

[hdl/spr_fifo.sv]
// Short command queue between front and back ends.
module spr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output spr_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (spr_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(spr_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(spr_pkg::QUEUE_DEPTH + 1);

  spr_pkg::cmd_t    mem_q [spr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(spr_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue read while empty");

endmodule

[hdl/spr_back.sv]
// Back end: writes the set stores, merges both sets and emits the status or merged list.
module spr_back #(
  parameter int unsigned MAX_PEERS = 16,
  parameter int unsigned PEER_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  spr_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [63:0]   peer_out_o,
  output logic          last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
  localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  spr_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]     ci_q, ci_d, ri_q, ri_d, n_q, n_d, k_q, k_d, cc_q, cc_d, rc_q, rc_d;
  logic                 fresh_q, fresh_d, cap_q, cap_d;
  logic                 oval_q, oval_d, olast_q, olast_d;
  spr_pkg::status_e     ostat_q, ostat_d;
  logic [PEER_BITS-1:0] opeer_q, opeer_d;

  logic                 cur_we, rdy_we, m_we;
  logic [PEER_BITS-1:0] cur_rd, rdy_rd, m_rd, cand;
  logic                 out_free, load_out, c_left, r_left, take_c, take_r;

  spr_ram #(.WIDTH(PEER_BITS), .DEPTH(MAX_PEERS)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cmd_i.idx[IDX_W-1:0]),
    .wdata_i (cmd_i.value[PEER_BITS-1:0]),
    .raddr_i (ci_d[IDX_W-1:0]),
    .rdata_o (cur_rd)
  );

  spr_ram #(.WIDTH(PEER_BITS), .DEPTH(MAX_PEERS)) u_rdy_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (cmd_i.idx[IDX_W-1:0]),
    .wdata_i (cmd_i.value[PEER_BITS-1:0]),
    .raddr_i (ri_d[IDX_W-1:0]),
    .rdata_o (rdy_rd)
  );

  spr_ram #(.WIDTH(PEER_BITS), .DEPTH(MAX_PEERS)) u_merged_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (n_q[IDX_W-1:0]),
    .wdata_i (cand),
    .raddr_i (k_d[IDX_W-1:0]),
    .rdata_o (m_rd)
  );

  always_comb begin
    state_d  = state_q;
    ci_d     = ci_q;
    ri_d     = ri_q;
    n_d      = n_q;
    k_d      = k_q;
    cc_d     = cc_q;
    rc_d     = rc_q;
    fresh_d  = fresh_q;
    cap_d    = cap_q;
    ostat_d  = ostat_q;
    opeer_d  = opeer_q;
    olast_d  = olast_q;
    pop_o    = 1'b0;
    cur_we   = 1'b0;
    rdy_we   = 1'b0;
    m_we     = 1'b0;
    load_out = 1'b0;

    out_free = !oval_q || !out_stall_i;
    c_left   = ci_q < cc_q;
    r_left   = ri_q < rc_q;
    take_c   = !r_left || (c_left && (cur_rd < rdy_rd));
    take_r   = !take_c && (!c_left || (rdy_rd < cur_rd));
    cand     = take_r ? rdy_rd : cur_rd;

    unique case (state_q)
      spr_pkg::B_IDLE: begin
        // Park read pointers at the heads so the merge finds its first data ready
        ci_d  = '0;
        ri_d  = '0;
        n_d   = '0;
        k_d   = '0;
        cap_d = 1'b0;
        if (!empty_i) begin
          unique case (cmd_i.kind)
            spr_pkg::CMD_LOAD_CUR: begin
              pop_o  = 1'b1;
              cur_we = 1'b1;
            end
            spr_pkg::CMD_LOAD_RDY: begin
              pop_o  = 1'b1;
              rdy_we = 1'b1;
            end
            spr_pkg::CMD_FINISH: begin
              if (cmd_i.cur_bad || cmd_i.rdy_bad) begin
                if (out_free) begin
                  pop_o    = 1'b1;
                  load_out = 1'b1;
                  ostat_d  = cmd_i.cur_bad ? spr_pkg::ST_BAD_CURRENT : spr_pkg::ST_BAD_READY;
                  opeer_d  = '0;
                  olast_d  = 1'b1;
                end
              end else begin
                pop_o   = 1'b1;
                cc_d    = cmd_i.cur_count[CNT_W-1:0];
                rc_d    = cmd_i.rdy_count[CNT_W-1:0];
                fresh_d = cmd_i.fresh;
                state_d = spr_pkg::B_MERGE;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      spr_pkg::B_MERGE: begin
        if (!c_left && !r_left) begin
          state_d = spr_pkg::B_DECIDE;
        end else if (n_q == CNT_W'(MAX_PEERS)) begin
          cap_d   = 1'b1;
          state_d = spr_pkg::B_DECIDE;
        end else begin
          m_we = 1'b1;
          n_d  = n_q + 1'b1;
          // Advance both sides on a duplicate
          if (take_c || !take_r) begin
            ci_d = ci_q + 1'b1;
          end
          if (!take_c) begin
            ri_d = ri_q + 1'b1;
          end
        end
      end
      spr_pkg::B_DECIDE: begin
        if (cap_q || (n_q == cc_q) || ((cc_q != '0) && !fresh_q)) begin
          if (out_free) begin
            load_out = 1'b1;
            opeer_d  = '0;
            olast_d  = 1'b1;
            state_d  = spr_pkg::B_IDLE;
            if (cap_q) begin
              ostat_d = spr_pkg::ST_CAPACITY;
            end else if (n_q == cc_q) begin
              ostat_d = spr_pkg::ST_UNCHANGED;
            end else begin
              ostat_d = spr_pkg::ST_DEFERRED;
            end
          end
        end else begin
          state_d = spr_pkg::B_EMIT;
        end
      end
      spr_pkg::B_EMIT: begin
        // Hold the read address while the receiver stalls
        if (out_free) begin
          load_out = 1'b1;
          ostat_d  = spr_pkg::ST_PUBLISHED;
          opeer_d  = m_rd;
          olast_d  = (k_q == n_q - CNT_W'(1));
          k_d      = k_q + 1'b1;
          if (k_q == n_q - CNT_W'(1)) begin
            state_d = spr_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_d = spr_pkg::B_IDLE;
      end
    endcase

    oval_d = load_out || (oval_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spr_pkg::B_IDLE;
      ci_q    <= '0;
      ri_q    <= '0;
      n_q     <= '0;
      k_q     <= '0;
      cc_q    <= '0;
      rc_q    <= '0;
      fresh_q <= 1'b0;
      cap_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ci_q    <= ci_d;
      ri_q    <= ri_d;
      n_q     <= n_d;
      k_q     <= k_d;
      cc_q    <= cc_d;
      rc_q    <= rc_d;
      fresh_q <= fresh_d;
      cap_q   <= cap_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ostat_q <= ostat_d;
      opeer_q <= opeer_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o = oval_q;
  assign status_o    = ostat_q;
  assign peer_out_o  = spr_pkg::PEER_W_MAX'(opeer_q);
  assign last_o      = olast_q;

  a_single_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && (ostat_q != spr_pkg::ST_PUBLISHED)) |-> (olast_q && (opeer_q == '0)))
    else $error("status-only request without last or with a nonzero peer");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spr_pkg::B_EMIT) |-> ((n_q != '0) && (k_q < n_q)))
    else $error("emit pointer outside the merged list");

endmodule

[hdl/sorted_peer_set_union.sv]
// Top level of the sorted peer set union block: front end, command queue and back end.
//
// Input channel (in_valid_i / in_stall_o): one request per accepted cycle. op_i 0 loads an
// element of the current set, 1 an element of the ready set, 2 finishes the round; 3 is
// taken and ignored. Loads and finishes are checked in the front end and queued in a
// two-entry command queue; in_stall_o is high only while that queue is full.
// Output channel (out_valid_o / out_stall_i): one status, or the merged list one element
// per request, with last_o on the final request of each finish.
// Throughput: loads run at one per cycle while the queue is not full. A finish holds the
// back end for one merge step per union element, at most MAX_PEERS steps since a larger
// union stops at capacity, plus a last merge step that sees the end of the merge and the
// B_DECIDE state that settles the status, then one output request per cycle while the
// receiver does not stall; the merge walks the single read port of each set RAM once a
// cycle. An error status goes straight into the output register as the finish leaves the
// queue; other statuses are settled in B_DECIDE and a merged list is sent from B_EMIT.
// Reset clears counts, error flags, the queue and the output valid flag; the set RAMs are
// not cleared and are never read before they are written in the current round.
// While the receiver stalls the output register holds, the back end waits once it has a
// result to send and the queue fills, after which the input side stalls too.
module sorted_peer_set_union #(
  parameter int unsigned MAX_PEERS = 16,
  parameter int unsigned PEER_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] peer_in_i,
  input  logic        fresh_boundary_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [63:0] peer_out_o,
  output logic        last_o
);

  logic          push, pop, full, empty;
  spr_pkg::cmd_t push_cmd, head_cmd;

  spr_front #(.MAX_PEERS(MAX_PEERS), .PEER_BITS(PEER_BITS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .peer_in_i        (peer_in_i),
    .fresh_boundary_i (fresh_boundary_i),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  spr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  spr_back #(.MAX_PEERS(MAX_PEERS), .PEER_BITS(PEER_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .peer_out_o  (peer_out_o),
    .last_o      (last_o)
  );

endmodule
